// ===== hw/rtl/mbcrop_pkg.sv =====
// Shared types, constants and codes for the multi-box crop filter.
package mbcrop_pkg;

  localparam int MaxBoxesDef = 16;
  localparam int FracBitsDef = 16;
  localparam int CoordW = 32;
  localparam int BoundW = 33;
  localparam int TransW = 50;
  localparam int MaskW = 16;

  typedef enum logic [1:0] {
    ACT_POINT = 2'd0,
    ACT_BOX   = 2'd1,
    ACT_ROW   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_REMOVE    = 2'd0,
    REG_TRANSFORM = 2'd1,
    REG_MIN_Z     = 2'd2,
    REG_BOX_COUNT = 2'd3
  } reg_index_t;

  // Control that travels down the pipeline with each point.
  typedef struct packed {
    logic valid;
    logic is_point;
  } stage_ctl_t;

endpackage

// ===== hw/rtl/multi_box_point_crop_filter.sv =====
// Top level of the multi-box point crop filter.
// Crops a stream of Q16.16 points against up to MAX_BOXES axis-aligned boxes.
// Each input word is a point, a box load or a transform row load, chosen by
// action. Words are taken one per cycle: a point passes an input register, the
// multiply stage, the floor-and-sum stage and the box compare stage, and then
// the output register, and the sustained rate is one word per clock as long
// as out_stall is low. A stalled output word freezes the whole pipeline in
// place and raises in_stall. Row loads are stored as they are accepted and box
// loads after their own load registers, so both take effect in stream order:
// every point accepted before a load sees the old contents and every point
// after it the new ones. Points dropped for point_valid low, for z below
// min_z, or by the keep/remove rule produce no output word. Output coordinates
// are the original untransformed values; in remove mode the mask is zero.
module multi_box_point_crop_filter import mbcrop_pkg::*; #(
  parameter int MAX_BOXES = MaxBoxesDef,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [3:0]        slot,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic signed [31:0] offset_t,
  input  logic [30:0]       half_x,
  input  logic [30:0]       half_y,
  input  logic [30:0]       half_z,
  input  logic              point_valid,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [15:0]       inside_mask,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int Depth = 4;

  logic              drop_inside, transform_points;
  logic signed [31:0] min_z;
  logic [4:0]        box_count;
  reg_index_t        reg_sel;
  logic signed [CoordW-1:0] affine [3][4];

  // The pipeline advances unless a finished word blocks the output register.
  logic adv, in_acc;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_acc = in_valid && adv;
  assign pready = 1'b1;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_inside <= 1'b1;
      transform_points <= 1'b0;
      min_z <= 32'sh8000_0000;
      box_count <= 5'd1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_REMOVE:    drop_inside <= pwdata[0];
        REG_TRANSFORM: transform_points <= pwdata[0];
        REG_MIN_Z:     min_z <= pwdata;
        REG_BOX_COUNT: box_count <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_REMOVE:    prdata = {31'd0, drop_inside};
      REG_TRANSFORM: prdata = {31'd0, transform_points};
      REG_MIN_Z:     prdata = min_z;
      REG_BOX_COUNT: prdata = {27'd0, box_count};
    endcase
  end

  // Transform rows reset to identity.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 4; k++)
          affine[r][k] <= (r == k) ? (CoordW'(1) << FRAC_BITS) : '0;
    end else if (in_acc && action_t'(action) == ACT_ROW && slot < 4'd3) begin
      affine[slot[1:0]][0] <= coord_x;
      affine[slot[1:0]][1] <= coord_y;
      affine[slot[1:0]][2] <= coord_z;
      affine[slot[1:0]][3] <= offset_t;
    end
  end

  // Point pipeline: control and original coordinates travel alongside.
  stage_ctl_t        ctl [Depth];
  logic signed [31:0] px [Depth];
  logic signed [31:0] py [Depth];
  logic signed [31:0] pz [Depth];
  logic              s0_point;
  logic              s0_keep;
  logic signed [CoordW-1:0] pt0 [3];
  logic signed [TransW-1:0] tr [3];
  logic [MaskW-1:0]  mask;
  logic [CoordW-2:0] hv [3];
  logic signed [CoordW-1:0] cv [3];

  assign s0_point = in_acc && action_t'(action) == ACT_POINT;
  assign s0_keep = s0_point && point_valid && (coord_z >= min_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < Depth; s++) ctl[s] <= '0;
    end else if (adv) begin
      ctl[0] <= '{valid: s0_keep, is_point: s0_point};
      for (int s = 1; s < Depth; s++) ctl[s] <= ctl[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px[0] <= coord_x; py[0] <= coord_y; pz[0] <= coord_z;
      for (int s = 1; s < Depth; s++) begin
        px[s] <= px[s-1]; py[s] <= py[s-1]; pz[s] <= pz[s-1];
      end
    end
  end

  assign pt0[0] = px[0];
  assign pt0[1] = py[0];
  assign pt0[2] = pz[0];
  assign cv[0] = coord_x;
  assign cv[1] = coord_y;
  assign cv[2] = coord_z;
  assign hv[0] = half_x;
  assign hv[1] = half_y;
  assign hv[2] = half_z;

  mbcrop_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk(clk), .en(adv), .coef(affine), .pt(pt0),
    .bypass(!transform_points), .res(tr)
  );

  mbcrop_boxtest #(.MAX_BOXES(MAX_BOXES)) u_box (
    .clk(clk), .rst(rst), .en(adv),
    .wr(in_acc && action_t'(action) == ACT_BOX), .wr_slot(slot),
    .ctr(cv), .half(hv), .t(tr), .box_count(box_count), .mask(mask)
  );

  // Output register; the keep/remove decision is made on the registered mask.
  logic emit;
  assign emit = ctl[Depth-1].valid && (drop_inside ? (mask == '0) : (mask != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x <= px[Depth-1];
      out_y <= py[Depth-1];
      out_z <= pz[Depth-1];
      inside_mask <= mask;
    end
  end

  // A stalled output word must not be overwritten.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inside_mask))
    else $error("output word changed under stall");
  // In remove mode every emitted word has an empty mask.
  a_rm: assert property (@(posedge clk) disable iff (rst)
    adv && emit && drop_inside |=> inside_mask == '0)
    else $error("remove mode emitted a nonzero mask");
  // Non-point words never enter the pipeline as points.
  a_drop: assert property (@(posedge clk) disable iff (rst)
    adv && in_valid && action_t'(action) != ACT_POINT |=> !ctl[0].valid && !ctl[0].is_point)
    else $error("load word entered the point pipeline");

endmodule

// ===== hw/rtl/mbcrop_xform.sv =====
// Pipelined affine transform: products, then floor shift and sum.
module mbcrop_xform import mbcrop_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [CoordW-1:0] coef [3][4],
  input  logic signed [CoordW-1:0] pt   [3],
  input  logic                     bypass,
  output logic signed [TransW-1:0] res  [3]
);

  logic signed [2*CoordW-1:0] prod [3][3];
  logic signed [CoordW-1:0]   offs [3];
  logic signed [CoordW-1:0]   pt_q [3];
  logic                       byp_q;

  // Stage one: nine 32x32 products.
  always_ff @(posedge clk) begin
    if (en) begin
      byp_q <= bypass;
      for (int r = 0; r < 3; r++) begin
        pt_q[r] <= pt[r];
        offs[r] <= coef[r][3];
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= coef[r][k] * pt[k];
        end
      end
    end
  end

  // Stage two: arithmetic shift floors; three terms plus offset, or the untransformed point in bypass.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        if (byp_q) begin
          res[r] <= TransW'(pt_q[r]);
        end else begin
          res[r] <= TransW'(prod[r][0] >>> FRAC_BITS) + TransW'(prod[r][1] >>> FRAC_BITS)
                  + TransW'(prod[r][2] >>> FRAC_BITS) + TransW'(offs[r]);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/mbcrop_boxtest.sv =====
// Box bound store and parallel inclusive compare against the first box_count boxes (at most MaskW).
module mbcrop_boxtest import mbcrop_pkg::*; #(
  parameter int MAX_BOXES = MaxBoxesDef
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     wr,
  input  logic [3:0]               wr_slot,
  input  logic signed [CoordW-1:0] ctr  [3],
  input  logic [CoordW-2:0]        half [3],
  input  logic signed [TransW-1:0] t    [3],
  input  logic [4:0]               box_count,
  output logic [MaskW-1:0]         mask
);

  localparam int Nb = (MAX_BOXES < MaskW) ? MAX_BOXES : MaskW;

  logic signed [BoundW-1:0] lo [MAX_BOXES][3];
  logic signed [BoundW-1:0] hi [MAX_BOXES][3];
  logic [MaskW-1:0] hit;

  // A box load walks two stages before it is stored, so it lands in stream
  // order relative to the points that are still ahead of it in the pipeline.
  logic                     wr_q1, wr_q2;
  logic [3:0]               slot_q1, slot_q2;
  logic signed [BoundW-1:0] lo_q1 [3];
  logic signed [BoundW-1:0] hi_q1 [3];
  logic signed [BoundW-1:0] lo_q2 [3];
  logic signed [BoundW-1:0] hi_q2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q1 <= 1'b0;
      wr_q2 <= 1'b0;
    end else if (en) begin
      wr_q1 <= wr && (32'(wr_slot) < MAX_BOXES);
      wr_q2 <= wr_q1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot_q1 <= wr_slot;
      slot_q2 <= slot_q1;
      for (int k = 0; k < 3; k++) begin
        lo_q1[k] <= BoundW'(ctr[k]) - BoundW'({1'b0, half[k]});
        hi_q1[k] <= BoundW'(ctr[k]) + BoundW'({1'b0, half[k]});
        lo_q2[k] <= lo_q1[k];
        hi_q2[k] <= hi_q1[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && wr_q2) begin
      for (int k = 0; k < 3; k++) begin
        lo[slot_q2][k] <= lo_q2[k];
        hi[slot_q2][k] <= hi_q2[k];
      end
    end
  end

  always_comb begin
    hit = '0;
    for (int i = 0; i < Nb; i++) begin
      hit[i] = (32'(box_count) > i);
      for (int k = 0; k < 3; k++) begin
        if (t[k] < TransW'(lo[i][k]) || t[k] > TransW'(hi[i][k])) hit[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) mask <= hit;
  end

endmodule
